/* hw/rtl/lcg_xor_packet_scrambler_defines.svh */
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler assertion macros
// Shared macros for the concurrent checks on the scrambler ports.
// ----------------------------------------------------------------------------
`ifndef LCG_XOR_PACKET_SCRAMBLER_DEFINES_SVH
`define LCG_XOR_PACKET_SCRAMBLER_DEFINES_SVH

// Generic clocked check with an active-low reset that disables it.
`define LXS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lxs check failed");

// Check on the block's own clock and reset.
`define LXS_ASSERT_CLK(name, prop) \
  `LXS_ASSERT(name, clk_i, rst_ni, prop)

`endif

/* hw/rtl/lxs_pkg.sv */
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler package
// Shared constants, register codes and structs of the scrambler.
// ----------------------------------------------------------------------------
package lxs_pkg;

  // Field and register widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned OutDataW = 40;

  // Reset values and fixed constants.
  localparam logic [WordW-1:0] MultReset     = 16'd1;
  localparam logic [WordW-1:0] KeyStartReset = 16'h0142;
  localparam logic [WordW-1:0] HdrBytes      = 16'd16;
  localparam logic [WordW-1:0] LenMax        = 16'hffff;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MULT = 1'b0,
    CFG_KEY  = 1'b1
  } cfg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic [WordW-1:0] mult;
    logic [WordW-1:0] key_start;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [WordW-1:0] packet_length;
    logic [WordW-1:0] checksum_sum;
    logic             is_final;
    logic [ByteW-1:0] coded_byte;
  } result_t;

endpackage

/* hw/rtl/lxs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler configuration registers
// Holds the key multiplier and the per-packet start key.
// ----------------------------------------------------------------------------
module lxs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lxs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lxs_pkg::WordW-1:0]       cfg_wdata_i,
  output lxs_pkg::cfg_t                   cfg_o
);

  lxs_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lxs_pkg::cfg_idx_e'(cfg_idx_i))
        lxs_pkg::CFG_MULT: cfg_d.mult      = cfg_wdata_i;
        lxs_pkg::CFG_KEY:  cfg_d.key_start = cfg_wdata_i;
        default:           cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult      <= lxs_pkg::MultReset;
      cfg_q.key_start <= lxs_pkg::KeyStartReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/lxs_core.sv */
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler core
// Key generator, byte scrambler, running checksum and length counter.
// ----------------------------------------------------------------------------
module lxs_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lxs_pkg::cfg_t               cfg_i,
  input  logic                        step_i,
  input  logic [lxs_pkg::ByteW-1:0]   body_byte_i,
  input  logic                        last_byte_i,
  output lxs_pkg::result_t            result_o
);

  logic [lxs_pkg::WordW-1:0]   key_q, key_d;
  logic [lxs_pkg::WordW-1:0]   sum_q, sum_d;
  logic [lxs_pkg::WordW-1:0]   count_q, count_d;
  logic [lxs_pkg::WordW-1:0]   key_src;
  logic [2*lxs_pkg::WordW-1:0] product;
  logic [lxs_pkg::WordW-1:0]   key_new;
  logic [lxs_pkg::ByteW-1:0]   coded;
  logic [lxs_pkg::WordW-1:0]   sum_new;
  logic [lxs_pkg::WordW-1:0]   count_new;

  // The first byte of a packet takes its key from the start register.
  assign key_src = (count_q == lxs_pkg::HdrBytes) ? cfg_i.key_start : key_q;
  assign product = key_src * cfg_i.mult;
  assign key_new = product[lxs_pkg::WordW-1:0] + lxs_pkg::WordW'(1);
  assign coded   = body_byte_i ^ key_new[lxs_pkg::ByteW-1:0];
  assign sum_new = sum_q + {{(lxs_pkg::WordW-lxs_pkg::ByteW){1'b0}}, coded};

  // Length counter saturates at its maximum.
  assign count_new = (count_q == lxs_pkg::LenMax) ? count_q
                                                  : count_q + lxs_pkg::WordW'(1);

  // State update; the last byte restarts sum and count for the next packet.
  always_comb begin
    key_d   = key_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (step_i) begin
      key_d = key_new;
      if (last_byte_i) begin
        sum_d   = '0;
        count_d = lxs_pkg::HdrBytes;
      end else begin
        sum_d   = sum_new;
        count_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= lxs_pkg::KeyStartReset;
      sum_q   <= '0;
      count_q <= lxs_pkg::HdrBytes;
    end else begin
      key_q   <= key_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign result_o.coded_byte    = coded;
  assign result_o.is_final      = last_byte_i;
  assign result_o.checksum_sum  = sum_new;
  assign result_o.packet_length = count_new;

endmodule

/* hw/rtl/lcg_xor_packet_scrambler.sv */
// Pipeline: an accepted input item is held in the input register until the result register
// is free or being emptied; its result item is then registered there and offered.
// Throughput: one item per cycle while the output is not stalled; the 16x16 key
// multiply sits between the input register and the result register and sets the cycle time.
// Reset (rst_ni low, asynchronous): both stages empty, multiplier 1,
// start key 0x142, checksum 0, length 16.
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler
// Scrambles packet body bytes with an LCG keystream and reports the running
// checksum and packet length per item.
// ----------------------------------------------------------------------------
module lcg_xor_packet_scrambler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [lxs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lxs_pkg::WordW-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lxs_pkg::ByteW-1:0]     s_axis_tdata_i,   // [7:0] body_byte
  input  logic                          s_axis_tlast_i,   // last_byte
  // Output stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] coded_byte, [23:8] checksum_sum, [39:24] packet_length
  output logic [lxs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o    // is_final
);

  lxs_pkg::cfg_t              cfg;
  lxs_pkg::result_t           result;
  lxs_pkg::result_t           out_q;
  logic                       in_vld_q, in_vld_d;
  logic [lxs_pkg::ByteW-1:0]  in_byte_q;
  logic                       in_last_q;
  logic                       out_vld_q, out_vld_d;
  logic                       advance;

  lxs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lxs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .body_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (result)
  );

  // An item moves on when the result register is free or being emptied.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready_o) begin
      in_vld_d = s_axis_tvalid_i;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.packet_length, out_q.checksum_sum, out_q.coded_byte};
  assign m_axis_tlast_o  = out_q.is_final;

endmodule

/* hw/rtl/lxs_checker.sv */
// ----------------------------------------------------------------------------
// LCG XOR packet scrambler checker
// Port-level checks on the scrambler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "lcg_xor_packet_scrambler_defines.svh"

module lxs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lxs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);

  logic [lxs_pkg::WordW-1:0]  out_len;
  logic [lxs_pkg::WordW-1:0]  out_sum;
  logic [lxs_pkg::ByteW-1:0]  out_coded;
  logic [lxs_pkg::OutDataW:0] out_payload;
  logic                       out_stall;
  logic                       first_out;
  logic                       in_acc;

  // Result fields as they leave the block.
  assign out_coded   = m_axis_tdata_o[lxs_pkg::ByteW-1:0];
  assign out_sum     = m_axis_tdata_o[lxs_pkg::ByteW+lxs_pkg::WordW-1:lxs_pkg::ByteW];
  assign out_len     = m_axis_tdata_o[lxs_pkg::OutDataW-1:lxs_pkg::ByteW+lxs_pkg::WordW];
  assign out_payload = {m_axis_tlast_o, m_axis_tdata_o};
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign first_out   = m_axis_tvalid_o &&
                       (out_len == (lxs_pkg::HdrBytes + lxs_pkg::WordW'(1)));
  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled result item holds its payload.
  `LXS_ASSERT_CLK(a_out_hold, out_stall |=> (m_axis_tvalid_o && $stable(out_payload)))

  // Every result counts the header plus at least one body byte.
  `LXS_ASSERT_CLK(a_len_min, m_axis_tvalid_o |-> (out_len > lxs_pkg::HdrBytes))

  // The first byte of a packet carries a checksum equal to that byte.
  `LXS_ASSERT_CLK(a_first_sum, first_out |-> (out_sum == lxs_pkg::WordW'(out_coded)))

  // An accepted input item is followed by a valid result item, once it has passed the input and result registers.
  `LXS_ASSERT_CLK(a_in_to_out, in_acc |-> ##2 m_axis_tvalid_o)

endmodule

bind lcg_xor_packet_scrambler lxs_checker u_lxs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
